### design/hlg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huber loss gradient package
// Shared item types, widths and defaults of the Huber loss gradient block.
// ----------------------------------------------------------------------------
package hlg_pkg;

  localparam int DELTA_W          = 15;
  localparam int DIFF_W           = 17;
  localparam int OPA_W            = 17;
  localparam int OPB_W            = 18;
  localparam int PROD_W           = OPA_W + OPB_W;
  localparam int LOSS_W           = PROD_W - 1;
  localparam int SUM_W            = 48;
  localparam int MEAN_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 15'd256;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic signed [15:0] target;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] gradient;
    logic [MEAN_W-1:0]        mean_loss;
    logic                     loss_valid;
  } out_item_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] grad;
    logic [OPA_W-1:0]         op_a;
    logic [OPB_W-1:0]         op_b;
    logic                     last;
  } work_item_t;

endpackage : hlg_pkg
`default_nettype wire

### design/hlg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huber loss gradient front end
// Holds the delta register, accepts items and classifies each difference as
// quadratic or linear, forming the gradient and the loss multiplier operands.
// ----------------------------------------------------------------------------
module hlg_front
  import hlg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire in_item_t           in_data,
  input  wire logic               q_full,
  output      logic               q_wr,
  output      work_item_t         q_wr_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [DELTA_W-1:0] cfg_data
);

  logic [DELTA_W-1:0]       delta_r;
  logic [DELTA_W-1:0]       delta_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [DIFF_W-1:0]        delta_ext;
  logic                     quad;

  assign cfg_ready = 1'b1;
  assign delta_nxt = (cfg_valid && cfg_ready) ? cfg_data : delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RESET;
    end else begin
      delta_r <= delta_nxt;
    end
  end

  always_comb begin
    diff      = {in_data.prediction[15], in_data.prediction}
              - {in_data.target[15], in_data.target};
    mag       = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    delta_ext = DIFF_W'(delta_r);
    quad      = (mag <= delta_ext);

    q_wr_data.last = in_data.last_element;
    if (quad) begin
      q_wr_data.grad = diff;
      q_wr_data.op_a = mag;
      q_wr_data.op_b = {1'b0, mag};
    end else begin
      q_wr_data.grad = diff[DIFF_W-1] ? (~delta_ext + DIFF_W'(1)) : delta_ext;
      q_wr_data.op_a = delta_ext;
      q_wr_data.op_b = {mag, 1'b0} - OPB_W'(delta_r);
    end
  end

  assign q_wr = push && !q_full;

endmodule : hlg_front
`default_nettype wire

### design/hlg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huber loss gradient work queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hlg_queue
  import hlg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr,
  input  wire work_item_t wr_data,
  output      logic       full,
  input  wire logic       rd,
  output      work_item_t rd_data,
  output      logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] rp_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule : hlg_queue
`default_nettype wire

### design/hlg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huber loss gradient back end
// Multiplies out the per-item loss, accumulates sum and count, divides for
// the mean on the last item and holds the result register.
// ----------------------------------------------------------------------------
module hlg_back
  import hlg_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire work_item_t q_data,
  output      logic       q_rd,
  input  wire logic       pop,
  output      logic       empty,
  output      out_item_t  out_data
);

  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     m_v_r, m_v_nxt;
  logic [LOSS_W-1:0]        m_loss_r, m_loss_nxt;
  logic signed [DIFF_W-1:0] m_grad_r, m_grad_nxt;
  logic                     m_last_r, m_last_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SUM_W-1:0]         dq_r, dq_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         dv_r, dv_nxt;
  logic [DIV_CNT_W-1:0]     bc_r, bc_nxt;
  logic signed [DIFF_W-1:0] hold_grad_r, hold_grad_nxt;
  logic                     out_v_r, out_v_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W:0]    trial;
  logic              trial_ge;
  logic              out_free;
  logic              m_adv;

  assign empty    = !out_v_r;
  assign out_data = out_data_r;
  assign out_free = !out_v_r || pop;
  assign m_adv    = m_v_r && (state_r == S_IDLE) && (m_last_r || out_free);
  assign q_rd     = !q_empty && (!m_v_r || m_adv);

  always_comb begin
    prod     = PROD_W'(q_data.op_a) * PROD_W'(q_data.op_b);
    sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(m_loss_r);
    sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    cnt_inc  = (cnt_r < CNT_W'(MAX_ELEMENTS)) ? cnt_r + CNT_W'(1) : cnt_r;
    trial    = {rem_r, dq_r[SUM_W-1]};
    trial_ge = (trial >= {1'b0, dv_r});
  end

  always_comb begin
    state_nxt     = state_r;
    m_v_nxt       = m_v_r;
    m_loss_nxt    = m_loss_r;
    m_grad_nxt    = m_grad_r;
    m_last_nxt    = m_last_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    bc_nxt        = bc_r;
    hold_grad_nxt = hold_grad_r;
    out_v_nxt     = out_v_r && !pop;
    out_data_nxt  = out_data_r;

    if (m_adv) begin
      m_v_nxt = 1'b0;
    end
    if (q_rd) begin
      m_v_nxt    = 1'b1;
      m_loss_nxt = prod[PROD_W-1:1];
      m_grad_nxt = q_data.grad;
      m_last_nxt = q_data.last;
    end

    case (state_r)
      S_IDLE: begin
        if (m_adv) begin
          if (m_last_r) begin
            sum_nxt       = '0;
            cnt_nxt       = '0;
            dq_nxt        = sum_sat;
            dv_nxt        = cnt_inc;
            rem_nxt       = '0;
            bc_nxt        = DIV_CNT_W'(SUM_W - 1);
            hold_grad_nxt = m_grad_r;
            state_nxt     = S_DIV;
          end else begin
            sum_nxt                 = sum_sat;
            cnt_nxt                 = cnt_inc;
            out_v_nxt               = 1'b1;
            out_data_nxt.gradient   = m_grad_r;
            out_data_nxt.mean_loss  = '0;
            out_data_nxt.loss_valid = 1'b0;
          end
        end
      end
      S_DIV: begin
        rem_nxt = trial_ge ? CNT_W'(trial - {1'b0, dv_r}) : trial[CNT_W-1:0];
        dq_nxt  = {dq_r[SUM_W-2:0], trial_ge};
        bc_nxt  = bc_r - DIV_CNT_W'(1);
        if (bc_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_v_nxt               = 1'b1;
          out_data_nxt.gradient   = hold_grad_r;
          out_data_nxt.mean_loss  = (|dq_r[SUM_W-1:MEAN_W]) ? '1 : dq_r[MEAN_W-1:0];
          out_data_nxt.loss_valid = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      m_v_r   <= m_v_nxt;
      out_v_r <= out_v_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
    m_loss_r    <= m_loss_nxt;
    m_grad_r    <= m_grad_nxt;
    m_last_r    <= m_last_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dv_r        <= dv_nxt;
    bc_r        <= bc_nxt;
    hold_grad_r <= hold_grad_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (m_adv && m_last_r) |=> (state_r == S_DIV && sum_r == '0 && cnt_r == '0))
    else $error("last item did not start the division with cleared totals");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dv_r != '0))
    else $error("division started with a zero count");

  a_no_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("back end read an empty queue");

  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && m_v_r) |=> (m_v_r && $stable(m_loss_r)))
    else $error("multiplier stage moved during a division");

endmodule : hlg_back
`default_nettype wire

### design/huber_loss_gradient_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huber loss gradient top level
// Streams prediction and target pairs, returns the Huber gradient of each
// and the mean Huber loss on the item marked last.
//
//   Channel  Ports                            Handshake
//   input    push, full, in_data              accepted when push and !full
//   result   empty, pop, out_data             accepted when pop and !empty
//   config   cfg_valid, cfg_ready, cfg_data   written when valid and ready
//
// One item can be accepted every cycle while full is low; an ordinary item
// passes through the queue, the multiplier stage and the result register.
// The item marked last runs a bit-serial 48-step division in the back end,
// during which the back end pauses while the front end fills the queue, raising full.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module huber_loss_gradient_top
  import hlg_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output      logic               full,
  input  wire in_item_t           in_data,
  output      logic               empty,
  input  wire logic               pop,
  output      out_item_t          out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [DELTA_W-1:0] cfg_data
);

  logic       q_wr;
  logic       q_rd;
  logic       q_full;
  logic       q_empty;
  work_item_t q_wr_data;
  work_item_t q_rd_data;

  assign full = q_full;

  hlg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (q_wr_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hlg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  hlg_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule : huber_loss_gradient_top
`default_nettype wire
